// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: field widths and the per-cell control struct.
// No dependencies; every other file imports it.
package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Control group sent from the top level to each cell.
  typedef struct packed {
    logic clear;  // drop the entry (capacity write)
    logic shift;  // take the neighbor's entry
    logic keep;   // position lies inside the active capacity
  } lkvc_ctrl_t;

endpackage

// ===== rtl/lkvc_if.sv =====
// Valid/ready channel interfaces for the cache request and response streams.
// Depends on lkvc_pkg.
interface lkvc_req_if;
  import lkvc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// ===== rtl/lkvc_cell.sv =====
// One position of the recency chain: holds a valid bit, key and value.
// Depends on lkvc_pkg.
module lkvc_cell #(
  parameter int SW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkvc_pkg::lkvc_ctrl_t      ctrl_i,
  input  logic [lkvc_pkg::KEY_W-1:0] lookup_key_i,
  input  logic                      prev_valid_i,
  input  logic [lkvc_pkg::KEY_W-1:0] prev_key_i,
  input  logic [SW-1:0]             prev_value_i,
  output logic                      valid_o,
  output logic [lkvc_pkg::KEY_W-1:0] key_o,
  output logic [SW-1:0]             value_o,
  output logic                      match_o
);
  import lkvc_pkg::*;

  logic             valid_q;
  logic [KEY_W-1:0] key_q;
  logic [SW-1:0]    value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i && ctrl_i.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign match_o = valid_q && (key_q == lookup_key_i);
  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache: a chain of CAP cells ordered by recency, cell 0 most recent.
// The output register captures the result when its request transaction is accepted.
// Throughput: one transaction per cycle while the response side takes results; the
// combinational key compare across the chain plus the shift of the cells up to the
// hit position set that figure. Reset: asynchronous, active low; store empty,
// capacity = CAP. A capacity write clears all cells together; no clearing pass.
module lru_key_value_cache #(
  parameter int CAP       = 16,
  parameter int DATA_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  // Stored value width: narrow data keeps its low bits, wide data keeps the 32 input bits.
  localparam int SW = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
  // Width of the capacity limit: must hold CAP and any 5-bit write.
  localparam int CW = ($clog2(CAP + 1) > CFG_W) ? $clog2(CAP + 1) : CFG_W;

  // Active capacity, already clamped to 1..CAP.
  logic [CW-1:0] limit_q;

  logic [CAP-1:0]   cell_valid;
  logic [KEY_W-1:0] cell_key   [CAP];
  logic [SW-1:0]    cell_value [CAP];
  logic [CAP-1:0]   cell_match;
  // ahead[i]: some cell ahead of i (more recent) matched the key.
  logic [CAP-1:0]   ahead;

  logic             accept;
  logic             hit;
  logic             update;
  logic [SW-1:0]    hit_value;
  logic [SW-1:0]    head_value;

  logic             rsp_valid_q;
  logic             rsp_hit_q;
  logic [DATA_W-1:0] rsp_value_q;
  logic [DATA_W-1:0] rsp_value_d;

  // Capacity register: zero acts as one, anything above CAP as CAP.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CW'(CAP);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        limit_q <= CW'(1);
      end else if (CW'(cfg_wdata_i) > CW'(CAP)) begin
        limit_q <= CW'(CAP);
      end else begin
        limit_q <= CW'(cfg_wdata_i);
      end
    end
  end

  // Output register decouples the two sides; a new request is taken while the
  // current result is being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign hit = |cell_match;

  // Matching cell's value; keys are unique so at most one match.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAP; i++) begin
      hit_value = hit_value | (cell_value[i] & {SW{cell_match[i]}});
    end
  end

  // Any hit, or a put that misses, moves an entry to the head of the chain.
  // A hit at position p shifts cells 0..p; an insert shifts the whole chain and
  // the entry pushed past the capacity limit falls out (eviction).
  assign update     = accept && (hit || (req_i.kind == KIND_PUT));
  assign head_value = (req_i.kind == KIND_PUT) ? req_i.value[SW-1:0] : hit_value;

  assign ahead[0] = 1'b0;
  for (genvar i = 1; i < CAP; i++) begin : g_ahead
    assign ahead[i] = ahead[i-1] | cell_match[i-1];
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    lkvc_ctrl_t       ctrl;
    logic             prev_valid;
    logic [KEY_W-1:0] prev_key;
    logic [SW-1:0]    prev_value;

    assign ctrl.clear = cfg_we_i;
    assign ctrl.shift = update && !ahead[i];
    assign ctrl.keep  = CW'(i) < limit_q;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_key   = req_i.key;
      assign prev_value = head_value;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end

    lkvc_cell #(
      .SW (SW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .lookup_key_i (req_i.key),
      .prev_valid_i (prev_valid),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .valid_o      (cell_valid[i]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .match_o      (cell_match[i])
    );
  end

  // Result: put returns 0; get returns the sign-extended stored value or all ones.
  always_comb begin
    if (req_i.kind == KIND_PUT) begin
      rsp_value_d = '0;
    end else if (hit) begin
      rsp_value_d = DATA_W'(signed'(hit_value));
    end else begin
      rsp_value_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_hit_q   <= hit;
      rsp_value_q <= rsp_value_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.read_value = rsp_value_q;

endmodule

// ===== rtl/lkvc_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       req_kind_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_hit_i,
  input logic [lkvc_pkg::DATA_W-1:0] rsp_value_i,
  input logic                       cfg_we_i
);
  import lkvc_pkg::*;

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // Pending result is held until taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A put always reports zero data.
  a_put_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_kind_i == KIND_PUT) |=> (rsp_valid_i && rsp_value_i == '0))
    else $error("put returned nonzero data");

  // A get miss reports all ones.
  a_get_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_kind_i == KIND_GET) |=> (rsp_hit_i || rsp_value_i == '1))
    else $error("get miss returned wrong data");

  // Store is empty right after a capacity write.
  a_cfg_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i ##1 (req_acc && req_kind_i == KIND_GET) |=> !rsp_hit_i)
    else $error("hit right after capacity write");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_kind_i  (req_i.kind),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_value_i (rsp_o.read_value),
  .cfg_we_i    (cfg_we_i)
);
